>>> hw/rtl/rqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared constants, state types and the Phred+33 probability table for the
// read quality scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package rqs_pkg;

  // fixed field widths
  localparam int CFG_W      = 11;
  localparam int QUAL_W     = 8;
  localparam int OUT_Q_W    = 23;
  localparam int OUT_L_W    = 20;
  localparam int OUT_DATA_W = 96;

  // arithmetic constants
  localparam int TAB_BITS  = 16;
  localparam int CODE_LO   = 33;
  localparam int CODE_HI   = 126;
  localparam int TAB_DEPTH = 94;
  localparam int PCT       = 100;
  localparam int LEN_BIAS  = 5000;
  localparam int WIN_RESET = 250;

  // front sequencer states
  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  // back sequencer states
  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_MEAN = 9'b000000010,
    B_WINQ = 9'b000000100,
    B_LSC  = 9'b000001000,
    B_PROD = 9'b000010000,
    B_SQRT = 9'b000100000,
    B_FAC  = 9'b001000000,
    B_MUL  = 9'b010000000,
    B_OUT  = 9'b100000000
  } back_state_t;

  // probability of a correct call, 16 fraction bits, per quality 0..93
  localparam logic [15:0] QTAB [TAB_DEPTH] = '{
    16'd0,     16'd13479, 16'd24186, 16'd32690, 16'd39446, 16'd44812,
    16'd49074, 16'd52460, 16'd55149, 16'd57286, 16'd58982, 16'd60330,
    16'd61401, 16'd62251, 16'd62927, 16'd63464, 16'd63890, 16'd64228,
    16'd64497, 16'd64711, 16'd64881, 16'd65015, 16'd65122, 16'd65208,
    16'd65275, 16'd65329, 16'd65371, 16'd65405, 16'd65432, 16'd65453,
    16'd65470, 16'd65484, 16'd65495, 16'd65503, 16'd65510, 16'd65515,
    16'd65520, 16'd65523, 16'd65526, 16'd65528, 16'd65529, 16'd65531,
    16'd65532, 16'd65533, 16'd65533, 16'd65534, 16'd65534, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535
  };

  // codes outside the printable quality range map to zero
  function automatic logic [15:0] code_prob(input logic [QUAL_W-1:0] code);
    logic [15:0] v;
    if (code < QUAL_W'(CODE_LO) || code > QUAL_W'(CODE_HI)) begin
      v = '0;
    end else begin
      v = QTAB[7'(code - QUAL_W'(CODE_LO))];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rqs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_queue
// Two-entry queue of per-read totals between the front and back sequencers.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  logic [W-1:0] slots [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slots[rp];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && empty && !pop) |=> !empty)
    else $error("queue lost a pushed read");

endmodule

`default_nettype wire

>>> hw/rtl/rqs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_front
// Takes quality characters, keeps the running and sliding-window sums over a
// ring memory, and hands per-read totals to the queue on the last base.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_front #(
  parameter int WINDOW_MAX   = 1024,
  parameter int MAX_READ_LEN = 1048575,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [rqs_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [rqs_pkg::QUAL_W-1:0]  s_tdata,
  input  wire logic                        s_tlast,
  input  wire logic                        q_full,
  output logic                             push,
  output logic [$clog2(MAX_READ_LEN+1)-1:0] rec_len,
  output logic [FRAC_BITS+$clog2(MAX_READ_LEN+1):0] rec_tot,
  output logic [FRAC_BITS+$clog2(WINDOW_MAX+1):0]   rec_min,
  output logic [$clog2(WINDOW_MAX+1)-1:0]  rec_aw,
  output logic                             rec_sat
);

  localparam int AWW  = $clog2(WINDOW_MAX + 1);
  localparam int PW   = $clog2(WINDOW_MAX);
  localparam int LENW = $clog2(MAX_READ_LEN + 1);
  localparam int PBW  = FRAC_BITS + 1;
  localparam int TOTW = PBW + LENW;
  localparam int WINW = PBW + AWW;

  rqs_pkg::front_state_t state;

  logic [rqs_pkg::CFG_W-1:0] win;
  logic [AWW-1:0]  aw;
  logic [PW-1:0]   pos;
  logic [LENW-1:0] bc;
  logic [TOTW-1:0] tot;
  logic [WINW-1:0] ws;
  logic [WINW-1:0] mn;
  logic            sat;
  logic [PBW-1:0]  p_q;
  logic            last_q;
  logic            skip_q;
  logic [PBW-1:0]  old;
  logic [PBW-1:0]  ring [WINDOW_MAX];

  logic            accept;
  logic [15:0]     tab_v;
  logic [PBW-1:0]  p_in;
  logic [AWW-1:0]  aw_clamp;
  logic            first;
  logic [PW-1:0]   rd_addr;
  logic            wr_en;
  logic [LENW-1:0] bc1;
  logic            in_fill;
  logic [WINW-1:0] ws_n;
  logic [WINW-1:0] mn_n;
  logic [PW:0]     pos_inc;
  logic [PW-1:0]   pos_n;
  logic [LENW-1:0] len_f;
  logic [TOTW-1:0] tot_f;
  logic [WINW-1:0] mn_f;
  logic            sat_f;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == rqs_pkg::F_IDLE) && !q_full;
  assign tab_v    = rqs_pkg::code_prob(s_tdata);
  assign first    = (bc == '0);
  assign rd_addr  = first ? '0 : pos;
  assign wr_en    = (state == rqs_pkg::F_UPD) && !skip_q;

  // table value rescaled to the fraction width
  generate
    if (FRAC_BITS >= rqs_pkg::TAB_BITS) begin : g_up
      assign p_in = PBW'(tab_v) << (FRAC_BITS - rqs_pkg::TAB_BITS);
    end else begin : g_down
      localparam int SH = rqs_pkg::TAB_BITS - FRAC_BITS;
      logic [16:0] rnd;
      assign rnd  = {1'b0, tab_v} + 17'(1 << (SH - 1));
      assign p_in = PBW'(rnd >> SH);
    end
  endgenerate

  // window size clamped to 1..WINDOW_MAX
  always_comb begin
    if (win == '0) begin
      aw_clamp = AWW'(1);
    end else if (32'(win) > 32'(WINDOW_MAX)) begin
      aw_clamp = AWW'(WINDOW_MAX);
    end else begin
      aw_clamp = AWW'(win);
    end
  end

  // sum updates for the base held in p_q
  always_comb begin
    bc1     = bc + LENW'(1);
    in_fill = 32'(bc1) <= 32'(aw);
    if (in_fill) begin
      ws_n = ws + WINW'(p_q);
    end else begin
      ws_n = ws + WINW'(p_q) - WINW'(old);
    end
    if (32'(bc1) == 32'(aw)) begin
      mn_n = ws_n;
    end else if (!in_fill && ws_n < mn) begin
      mn_n = ws_n;
    end else begin
      mn_n = mn;
    end
    pos_inc = {1'b0, pos} + (PW+1)'(1);
    pos_n   = (32'(pos_inc) >= 32'(aw)) ? '0 : pos_inc[PW-1:0];
    len_f   = skip_q ? bc  : bc1;
    tot_f   = skip_q ? tot : tot + TOTW'(p_q);
    mn_f    = skip_q ? mn  : mn_n;
    sat_f   = sat || (32'(len_f) >= 32'(MAX_READ_LEN));
  end

  assign push    = (state == rqs_pkg::F_UPD) && last_q;
  assign rec_len = len_f;
  assign rec_tot = tot_f;
  assign rec_min = mn_f;
  assign rec_aw  = aw;
  assign rec_sat = sat_f;

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      old <= ring[rd_addr];
    end
    if (wr_en) begin
      ring[pos] <= p_q;
    end
  end

  // window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= rqs_pkg::CFG_W'(rqs_pkg::WIN_RESET);
    end else if (cfg_we) begin
      win <= cfg_wdata;
    end
  end

  // per-base payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      p_q    <= p_in;
      last_q <= s_tlast;
      skip_q <= 32'(bc) >= 32'(MAX_READ_LEN);
    end
  end

  // sequencer and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqs_pkg::F_IDLE;
      aw    <= AWW'(rqs_pkg::WIN_RESET);
      pos   <= '0;
      bc    <= '0;
      tot   <= '0;
      ws    <= '0;
      mn    <= '0;
      sat   <= 1'b0;
    end else begin
      unique case (state)
        rqs_pkg::F_IDLE: begin
          if (accept) begin
            if (first) begin
              aw  <= aw_clamp;
              pos <= '0;
            end
            state <= rqs_pkg::F_UPD;
          end
        end
        rqs_pkg::F_UPD: begin
          if (last_q) begin
            bc  <= '0;
            tot <= '0;
            ws  <= '0;
            mn  <= '0;
            sat <= 1'b0;
            pos <= '0;
          end else begin
            bc  <= len_f;
            tot <= tot_f;
            mn  <= mn_f;
            sat <= sat_f;
            if (!skip_q) begin
              ws  <= ws_n;
              pos <= pos_n;
            end
          end
          state <= rqs_pkg::F_IDLE;
        end
        default: state <= rqs_pkg::F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rqs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_div #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dq;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, dq};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dq  <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dq}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rqs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounded to
// nearest as a final step.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_sqrt #(
  parameter int W = 46
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [W-1:0] x,
  output logic            done,
  output logic [W/2:0]    root
);

  localparam int HW = W / 2;
  localparam int RW = HW + 3;
  localparam int CW = $clog2(HW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  xs;
  logic [RW-1:0] rem;
  logic [HW-1:0] rt;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          fits;

  assign rem_sh = {rem[RW-3:0], xs[W-1:W-2]};
  assign trial  = RW'({rt, 2'b01});
  assign fits   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(HW);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  // one root bit per step, then round
  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= x;
      rem <= '0;
      rt  <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        xs  <= {xs[W-3:0], 2'b00};
        rem <= fits ? rem_sh - trial : rem_sh;
        rt  <= {rt[HW-2:0], fits};
      end else begin
        root <= (rem > RW'(rt)) ? (HW+1)'(rt) + (HW+1)'(1) : (HW+1)'(rt);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rqs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_back
// Per-read finishing: mean and window quality, length score, square root,
// window factor and final score, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_back #(
  parameter int WINDOW_MAX   = 1024,
  parameter int MAX_READ_LEN = 1048575,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [$clog2(MAX_READ_LEN+1)-1:0] rec_len,
  input  wire logic [FRAC_BITS+$clog2(MAX_READ_LEN+1):0] rec_tot,
  input  wire logic [FRAC_BITS+$clog2(WINDOW_MAX+1):0]   rec_min,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0] rec_aw,
  input  wire logic                        rec_sat,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [rqs_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int AWW  = $clog2(WINDOW_MAX + 1);
  localparam int LENW = $clog2(MAX_READ_LEN + 1);
  localparam int PBW  = FRAC_BITS + 1;
  localparam int WINW = PBW + AWW;
  localparam int QW   = FRAC_BITS + 7;
  localparam int SW   = 2 * QW;
  localparam int NA   = FRAC_BITS + LENW + 8;
  localparam int NB   = 2 * FRAC_BITS + 9;
  localparam int NC   = FRAC_BITS + AWW + 9;
  localparam int NAB  = (NA > NB) ? NA : NB;
  localparam int NW   = ((NAB > NC) ? NAB : NC) + 1;
  localparam int DA   = ((LENW > 13) ? LENW : 13) + 1;
  localparam int DB   = QW + 1;
  localparam int DW   = (DA > DB) ? DA : DB;
  localparam int MW   = QW + 1 + PBW;

  rqs_pkg::back_state_t state;

  logic [LENW-1:0] r_len;
  logic [WINW-1:0] r_min;
  logic [AWW-1:0]  r_aw;
  logic            r_sat;
  logic [QW-1:0]   mean;
  logic [QW-1:0]   winq;
  logic [QW-1:0]   lsc;
  logic [SW-1:0]   sq_x;
  logic [QW:0]     root;
  logic [PBW-1:0]  factor;
  logic [QW:0]     score;
  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic            div_done;
  logic [NW-1:0]   div_quo;
  logic [QW-1:0]   quo_q;
  logic            sq_start;
  logic            sq_done;
  logic [QW:0]     sq_root;
  logic            load;
  logic [DW-1:0]   len_den;
  logic [NW-1:0]   lsc_num;
  logic [MW-1:0]   fin_prod;

  assign q_pop   = (state == rqs_pkg::B_IDLE) && !q_empty;
  assign quo_q   = div_quo[QW-1:0];
  assign load    = (state == rqs_pkg::B_OUT) && (!m_tvalid || m_tready);
  assign len_den = DW'(r_len) + DW'(rqs_pkg::LEN_BIAS);
  assign lsc_num = ((NW'(r_len) * NW'(rqs_pkg::PCT)) << FRAC_BITS) + NW'(len_den >> 1);
  assign fin_prod = MW'(root) * MW'(factor) + MW'(1 << (FRAC_BITS - 1));

  rqs_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rqs_sqrt #(.W(SW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  // finishing sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rqs_pkg::B_IDLE;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      unique case (state)
        rqs_pkg::B_IDLE: begin
          if (!q_empty) begin
            div_num   <= NW'(rec_tot) * NW'(rqs_pkg::PCT) + NW'(rec_len >> 1);
            div_den   <= DW'(rec_len);
            div_start <= 1'b1;
            state     <= rqs_pkg::B_MEAN;
          end
        end
        rqs_pkg::B_MEAN: begin
          if (div_done) begin
            if (32'(r_len) > 32'(r_aw)) begin
              div_num   <= NW'(r_min) * NW'(rqs_pkg::PCT) + NW'(r_aw >> 1);
              div_den   <= DW'(r_aw);
              div_start <= 1'b1;
              state     <= rqs_pkg::B_WINQ;
            end else if (quo_q == '0) begin
              state <= rqs_pkg::B_OUT;
            end else begin
              div_num   <= lsc_num;
              div_den   <= len_den;
              div_start <= 1'b1;
              state     <= rqs_pkg::B_LSC;
            end
          end
        end
        rqs_pkg::B_WINQ: begin
          if (div_done) begin
            if (mean == '0) begin
              state <= rqs_pkg::B_OUT;
            end else begin
              div_num   <= lsc_num;
              div_den   <= len_den;
              div_start <= 1'b1;
              state     <= rqs_pkg::B_LSC;
            end
          end
        end
        rqs_pkg::B_LSC: begin
          if (div_done) begin
            state <= rqs_pkg::B_PROD;
          end
        end
        rqs_pkg::B_PROD: begin
          sq_start <= 1'b1;
          state    <= rqs_pkg::B_SQRT;
        end
        rqs_pkg::B_SQRT: begin
          if (sq_done) begin
            if (winq >= mean) begin
              state <= rqs_pkg::B_MUL;
            end else begin
              div_num   <= ((NW'(mean) + NW'(winq)) << FRAC_BITS) + NW'(mean);
              div_den   <= DW'(mean) << 1;
              div_start <= 1'b1;
              state     <= rqs_pkg::B_FAC;
            end
          end
        end
        rqs_pkg::B_FAC: begin
          if (div_done) begin
            state <= rqs_pkg::B_MUL;
          end
        end
        rqs_pkg::B_MUL: begin
          state <= rqs_pkg::B_OUT;
        end
        rqs_pkg::B_OUT: begin
          if (load) begin
            state <= rqs_pkg::B_IDLE;
          end
        end
        default: state <= rqs_pkg::B_IDLE;
      endcase
    end
  end

  // per-read working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_len <= rec_len;
      r_min <= rec_min;
      r_aw  <= rec_aw;
      r_sat <= rec_sat;
    end
    if (state == rqs_pkg::B_MEAN && div_done) begin
      mean <= quo_q;
      if (32'(r_len) <= 32'(r_aw)) begin
        winq <= quo_q;
      end
      if (quo_q == '0) begin
        score <= '0;
      end
    end
    if (state == rqs_pkg::B_WINQ && div_done) begin
      winq <= quo_q;
      if (mean == '0) begin
        score <= '0;
      end
    end
    if (state == rqs_pkg::B_LSC && div_done) begin
      lsc <= quo_q;
    end
    if (state == rqs_pkg::B_PROD) begin
      sq_x <= SW'(lsc) * SW'(mean);
    end
    if (state == rqs_pkg::B_SQRT && sq_done) begin
      root <= sq_root;
      factor <= PBW'(1) << FRAC_BITS;
    end
    if (state == rqs_pkg::B_FAC && div_done) begin
      factor <= div_quo[PBW-1:0];
    end
    if (state == rqs_pkg::B_MUL) begin
      score <= (QW+1)'(fin_prod >> FRAC_BITS);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'b0, r_sat,
                  rqs_pkg::OUT_L_W'(r_len),
                  rqs_pkg::OUT_Q_W'(winq),
                  rqs_pkg::OUT_Q_W'(mean),
                  rqs_pkg::OUT_Q_W'(score)};
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == rqs_pkg::B_MEAN || state == rqs_pkg::B_WINQ ||
                   state == rqs_pkg::B_LSC || state == rqs_pkg::B_FAC))
    else $error("divider started outside a divide step");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == rqs_pkg::B_MEAN)
    else $error("read popped without starting the mean");
  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> hw/rtl/read_quality_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_quality_scorer
// Sliding-window Phred+33 read quality score, one result per read.
// ----------------------------------------------------------------------------
// Usage
//   s_tdata[7:0] carries one quality character per transfer, s_tlast marks
//   the final base of a read. Each read gives one transfer on m_tdata.
//   cfg_we/cfg_wdata set the window size; it is taken at a read's first base.
// Pacing
//   The front takes a new base only after the update for the last one: the
//   ring memory is read in the accept cycle and written back in the update
//   cycle. The back runs up to four divides per read on one shared
//   bit-serial divider plus the iterative square root. Two finished reads
//   queue between the parts, so at default parameters reads of more than
//   about 110 bases stream without stalls on the input while m_tready
//   stays high.
// Reset
//   rst clears all read state and sets the window size to 250; the ring
//   memory needs no clearing.
// Stalls
//   A result waits in the output register while m_tready is low; the back
//   finishes one more queued read and the front stops when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module read_quality_scorer #(
  parameter int WINDOW_MAX   = 1024,
  parameter int MAX_READ_LEN = 1048575,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [rqs_pkg::CFG_W-1:0]  cfg_wdata,   // bases per window
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [rqs_pkg::QUAL_W-1:0] s_tdata,     // qual_char
  input  wire logic                       s_tlast,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // score[22:0], mean_q[45:23], win_q[68:46],
  // read_length[88:69], too_long[89], zero fill
  output logic [rqs_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int AWW  = $clog2(WINDOW_MAX + 1);
  localparam int LENW = $clog2(MAX_READ_LEN + 1);
  localparam int TOTW = FRAC_BITS + 1 + LENW;
  localparam int WINW = FRAC_BITS + 1 + AWW;
  localparam int RECW = LENW + TOTW + WINW + AWW + 1;

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            q_pop;
  logic [RECW-1:0] q_din;
  logic [RECW-1:0] q_dout;
  logic [LENW-1:0] f_len;
  logic [TOTW-1:0] f_tot;
  logic [WINW-1:0] f_min;
  logic [AWW-1:0]  f_aw;
  logic            f_sat;

  rqs_front #(
    .WINDOW_MAX   (WINDOW_MAX),
    .MAX_READ_LEN (MAX_READ_LEN),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .rec_len   (f_len),
    .rec_tot   (f_tot),
    .rec_min   (f_min),
    .rec_aw    (f_aw),
    .rec_sat   (f_sat)
  );

  // per-read record into the queue
  assign q_din = {f_sat, f_aw, f_min, f_tot, f_len};

  rqs_queue #(.W(RECW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  rqs_back #(
    .WINDOW_MAX   (WINDOW_MAX),
    .MAX_READ_LEN (MAX_READ_LEN),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .rec_len  (q_dout[LENW-1:0]),
    .rec_tot  (q_dout[LENW+TOTW-1:LENW]),
    .rec_min  (q_dout[LENW+TOTW+WINW-1:LENW+TOTW]),
    .rec_aw   (q_dout[RECW-2:LENW+TOTW+WINW]),
    .rec_sat  (q_dout[RECW-1]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

>>> verif/read_quality_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_quality_checker
// Watches the base and result streams of the read quality scorer, predicts
// each read's score, means and length, and compares every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module read_quality_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [95:0] m_tdata,
  output int               fail_count,
  output int               pending,
  output int               reads_seen
);

  localparam int WIN_CAP = 1024;
  localparam int LEN_CAP = 1048575;
  localparam longint ONE = 64'd65536;

  // packed from the top bit down, so score lands in the lowest bits
  typedef struct packed {
    logic        sat;
    logic [19:0] len;
    logic [22:0] win_q;
    logic [22:0] mean_q;
    logic [22:0] score;
  } read_result_t;

  read_result_t score_q[$];

  // predictor copy of the per-read state
  longint unsigned win_reg, win_act, nbases, prob_total, win_sum, win_min, rpos;
  bit              sat_flag;
  longint unsigned prob_hist[WIN_CAP];

  function automatic longint unsigned phred_prob(input logic [7:0] c);
    if (c < 8'd33 || c > 8'd126) return 0;
    return rqs_pkg::QTAB[c - 8'd33];
  endfunction

  function automatic longint unsigned rdiv(input longint unsigned n, input longint unsigned d);
    if (d == 0) return 0;
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned isqrt_round(input longint unsigned x);
    longint unsigned r, b, rem;
    r = 0; b = 64'd1 << 62; rem = x;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (rem > r) r++;
    return r;
  endfunction

  // one accepted base: update sums, on last queue the expected result
  task automatic take_base(input logic [7:0] c, input bit lst);
    longint unsigned p, mean, winq, lsc, root, fac, sc;
    read_result_t r;
    if (nbases == 0) begin
      win_act = (win_reg == 0) ? 1 : (win_reg > WIN_CAP ? WIN_CAP : win_reg);
      rpos = 0;
    end
    if (nbases < LEN_CAP) begin
      p = phred_prob(c);
      if (rpos >= win_act) rpos = 0;
      nbases++;
      prob_total += p;
      if (nbases <= win_act) win_sum += p;
      else win_sum = win_sum + p - prob_hist[rpos];
      prob_hist[rpos] = p;
      rpos++;
      if (rpos >= win_act) rpos = 0;
      if (nbases == win_act) win_min = win_sum;
      else if (nbases > win_act && win_sum < win_min) win_min = win_sum;
    end
    if (nbases >= LEN_CAP) sat_flag = 1;
    if (!lst) return;
    mean = rdiv(prob_total * 100, nbases);
    winq = (nbases <= win_act) ? mean : rdiv(win_min * 100, win_act);
    if (mean == 0) begin
      sc = 0;
    end else begin
      lsc  = rdiv(100 * nbases * ONE, nbases + 5000);
      root = isqrt_round(lsc * mean);
      fac  = (winq >= mean) ? ONE : ((mean + winq) * ONE + mean) / (2 * mean);
      sc   = (root * fac + ONE / 2) >> 16;
    end
    r.score = sc[22:0]; r.mean_q = mean[22:0]; r.win_q = winq[22:0];
    r.len = nbases[19:0]; r.sat = sat_flag;
    score_q = {score_q, r};
    nbases = 0; prob_total = 0; win_sum = 0; win_min = 0; sat_flag = 0; rpos = 0;
  endtask

  assign pending = score_q.size();

  always @(posedge clk) begin
    read_result_t got, want;
    if (rst) begin
      win_reg = rqs_pkg::WIN_RESET; win_act = rqs_pkg::WIN_RESET;
      nbases = 0; prob_total = 0; win_sum = 0; win_min = 0; sat_flag = 0; rpos = 0;
      score_q.delete();
      fail_count <= 0;
      reads_seen <= 0;
    end else begin
      // result transfer check
      if (m_tvalid && m_tready) begin
        got = m_tdata[89:0];
        reads_seen <= reads_seen + 1;
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = score_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch exp score=%0d mean=%0d win=%0d len=%0d sat=%0d",
                     $time, want.score, want.mean_q, want.win_q, want.len, want.sat);
            $display("%0t:          act score=%0d mean=%0d win=%0d len=%0d sat=%0d",
                     $time, got.score, got.mean_q, got.win_q, got.len, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) take_base(s_tdata, s_tlast);
      if (cfg_we) win_reg = cfg_wdata;
    end
  end
endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams reads of random quality characters through the scorer under
// several window sizes with random idling and a long output hold-off; the
// checker module predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int STALL_LIMIT = 20000;

  logic        clk, rst;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        s_tvalid, s_tready, s_tlast;
  logic [7:0]  s_tdata;
  logic        m_tvalid, m_tready;
  logic [95:0] m_tdata;
  int          fail_count, pending, reads_seen;
  int          idle_pct_in, idle_pct_out;
  bit          hold_out, stim_done;
  int          quiet_cycles, bases_sent;

  read_quality_scorer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  read_quality_checker u_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .reads_seen(reads_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // send one base, with random idle cycles before it; valid stays up after
  // the transfer until the next base or an explicit idle
  task automatic send_base(input logic [7:0] c, input bit lst);
    while ($urandom_range(99) < idle_pct_in) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= c; s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bases_sent++;
  endtask

  function automatic logic [7:0] rand_code();
    int k;
    k = $urandom_range(99);
    if (k < 80) return 8'(33 + $urandom_range(93));
    if (k < 88) return 8'($urandom_range(32));
    return 8'($urandom_range(255, 127));
  endfunction

  task automatic send_read(input int n, input int kind);
    for (int i = 0; i < n; i++)
      case (kind)
        0: send_base(rand_code(), i == n - 1);
        1: send_base(8'd33, i == n - 1);
        2: send_base(8'd126, i == n - 1);
        default: send_base(8'((i % 3 == 0) ? 35 : 70), i == n - 1);
      endcase
  endtask

  // wait for all results, allow the back stage to settle, then reconfigure
  task automatic set_window(input logic [10:0] w);
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // output ready, with random idling and an optional hold
  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      m_tready <= !hold_out && ($urandom_range(99) >= idle_pct_out);
    end
  end

  // watchdog on transfer activity
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we)
        quiet_cycles = 0;
      else if (pending != 0 || !stim_done)
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int w;
    rst = 1; cfg_we = 0; cfg_wdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tlast = 0;
    idle_pct_in = 32; idle_pct_out = 32; hold_out = 0; stim_done = 0; bases_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default window, edge codes, short reads, then windows 1, 3 and 0
    send_read(1, 1);
    send_read(1, 2);
    send_read(3, 1);
    send_base(8'd0, 0); send_base(8'd32, 0); send_base(8'd127, 0);
    send_base(8'd255, 0); send_base(8'd34, 0); send_base(8'd60, 1);
    set_window(11'd1);
    send_read(4, 3);
    send_read(2, 0);
    send_base(8'd40, 0);
    send_base(8'd50, 0);
    send_base(8'd45, 1);
    set_window(11'd3);
    send_read(5, 3);
    set_window(11'd0);
    send_read(3, 0);

    // random phases through several window sizes, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: w = 2047;
        1: w = 1024;
        2: w = 4;
        3: w = 1;
        default: w = $urandom_range(2, 40);
      endcase
      set_window(11'(w));
      idle_pct_in = (ph == 0) ? 0 : 32;
      idle_pct_out = (ph == 0) ? 0 : 32;
      for (int r = 0; r < 3; r++) begin
        int n;
        n = (ph == 0 && r == 0) ? 1030 : $urandom_range(1, 3 * (w > 6 ? 6 : w) + 4);
        if (ph == 6 && r == 1) begin
          // long output hold while bases keep streaming
          hold_out = 1;
          fork
            begin repeat (2000) @(posedge clk); hold_out = 0; end
          join_none
          for (int k = 0; k < 8; k++) send_read(3, 0);
        end
        send_read(n, $urandom_range(9) == 0 ? $urandom_range(1, 3) : 0);
      end
    end
    while (bases_sent < 1250) send_read($urandom_range(1, 30), 0);
    s_tvalid <= 0;
    stim_done = 1;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d bases in %0d scored reads, windows 0 to 2047 with clamping,",
             bases_sent, reads_seen);
    $display("invalid codes, a full-depth window read and a long output hold-off.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
